// ===== design/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// shared types and codes for the sparse matrix subtract merge block
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  // input actions
  localparam logic [1:0] ACT_M     = 2'd0;
  localparam logic [1:0] ACT_N     = 2'd1;
  localparam logic [1:0] ACT_M_END = 2'd2;
  localparam logic [1:0] ACT_N_END = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DIFF  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_ORDER = 2'd3;

  // merge step selected from the queue heads
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_M    = 2'd1;
  localparam logic [1:0] STEP_N    = 2'd2;
  localparam logic [1:0] STEP_BOTH = 2'd3;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the input item
    logic step;   // perform one merge step
    logic done;   // emit done marker and clear state
    logic flush;  // hand held result to output, marked last
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] step_kind;
    logic       step_emits;
    logic       done_cond;
    logic       hold_valid;
    logic       out_free;
  } status_t;

endpackage : ssm_pkg

`default_nettype wire

// ===== design/ssm_queue.sv =====
// ----------------------------------------------------------------------------
// ssm_queue
// circular element queue with registered head read
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_queue #(
  parameter  int DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clear,
  input  wire logic            push,
  input  wire ssm_pkg::entry_t push_data,
  input  wire logic            pop,
  output      logic [CW-1:0]   count,
  output      ssm_pkg::entry_t head_data
);
  import ssm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t        mem [DEPTH];
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    if (clear) begin
      head_next = '0;
    end else if (pop) begin
      head_next = inc(head);
    end else begin
      head_next = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (push) begin
        tail <= inc(tail);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // memory: write at tail, read the next head
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    head_data <= mem[head_next];
  end

endmodule : ssm_queue

`default_nettype wire

// ===== design/ssm_dp.sv =====
// ----------------------------------------------------------------------------
// ssm_dp
// datapath: queues, stream state, merge arithmetic, result hold and output
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_dp #(
  parameter int MAX_DIM     = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ssm_pkg::cmd_t      cmd,
  output      ssm_pkg::status_t   status,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         row,
  input  wire logic [7:0]         col,
  input  wire logic signed [31:0] value,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         kind,
  output      logic [7:0]         out_row,
  output      logic [7:0]         out_col,
  output      logic signed [32:0] difference,
  output      logic               last
);
  import ssm_pkg::*;

  localparam int          CW    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [16:0] DIM_W = 17'(MAX_DIM);

  // stream state
  logic        m_ended, n_ended;
  logic [15:0] m_last, n_last;
  logic        m_last_valid, n_last_valid;

  // held result, not yet known to be last
  logic               hold_valid;
  logic [1:0]         hold_kind;
  logic [7:0]         hold_row, hold_col;
  logic signed [32:0] hold_diff;

  // queues
  logic [CW-1:0] m_count, n_count;
  entry_t        m_head, n_head, new_entry;
  logic          m_push, n_push, m_pop, n_pop, q_clear;

  ssm_queue #(.DEPTH(QUEUE_DEPTH)) u_m_queue (
    .clk, .rst, .clear(q_clear), .push(m_push), .push_data(new_entry),
    .pop(m_pop), .count(m_count), .head_data(m_head)
  );

  ssm_queue #(.DEPTH(QUEUE_DEPTH)) u_n_queue (
    .clk, .rst, .clear(q_clear), .push(n_push), .push_data(new_entry),
    .pop(n_pop), .count(n_count), .head_data(n_head)
  );

  // input decode
  logic          is_elem, is_m, sel_ended, sel_last_valid, order_drop, full_drop;
  logic [15:0]   sel_last, in_pos;
  logic [CW-1:0] sel_count;
  logic          range_bad, ins_ok;

  always_comb begin
    is_elem        = (action == ACT_M) || (action == ACT_N);
    is_m           = (action == ACT_M);
    sel_ended      = is_m ? m_ended      : n_ended;
    sel_last_valid = is_m ? m_last_valid : n_last_valid;
    sel_last       = is_m ? m_last       : n_last;
    sel_count      = is_m ? m_count      : n_count;
    in_pos         = {row, col};
    range_bad      = ({9'd0, row} >= DIM_W) || ({9'd0, col} >= DIM_W);
    order_drop     = sel_ended || range_bad || (sel_last_valid && (in_pos <= sel_last));
    full_drop      = (sel_count == CW'(QUEUE_DEPTH));
    ins_ok         = cmd.load && is_elem && (value != '0) && !order_drop && !full_drop;
    new_entry      = '{row: row, col: col, value: value};
    m_push         = ins_ok && is_m;
    n_push         = ins_ok && !is_m;
  end

  // merge step
  logic               m_ne, n_ne;
  logic [15:0]        pm, pn;
  logic [1:0]         step_kind;
  logic signed [32:0] op_a, op_b, step_diff;
  logic               step_emits;

  always_comb begin
    m_ne = (m_count != '0);
    n_ne = (n_count != '0);
    pm   = {m_head.row, m_head.col};
    pn   = {n_head.row, n_head.col};
    if (m_ne && n_ne) begin
      if (pm < pn) begin
        step_kind = STEP_M;
      end else if (pm > pn) begin
        step_kind = STEP_N;
      end else begin
        step_kind = STEP_BOTH;
      end
    end else if (!m_ne && m_ended && n_ne) begin
      step_kind = STEP_N;
    end else if (!n_ne && n_ended && m_ne) begin
      step_kind = STEP_M;
    end else begin
      step_kind = STEP_NONE;
    end
    op_a       = (step_kind == STEP_N) ? '0 : {m_head.value[31], m_head.value};
    op_b       = (step_kind == STEP_M) ? '0 : {n_head.value[31], n_head.value};
    step_diff  = op_a - op_b;
    step_emits = (step_kind != STEP_NONE) &&
                 ((step_kind != STEP_BOTH) || (step_diff != '0));
    m_pop      = cmd.step && ((step_kind == STEP_M) || (step_kind == STEP_BOTH));
    n_pop      = cmd.step && ((step_kind == STEP_N) || (step_kind == STEP_BOTH));
    q_clear    = cmd.done;
  end

  logic out_free, push_res, move;

  always_comb begin
    out_free = !out_valid || out_ready;
    push_res = (cmd.step && step_emits) || cmd.done;
    move     = cmd.flush || (push_res && hold_valid);

    status.step_kind  = step_kind;
    status.step_emits = step_emits;
    status.done_cond  = m_ended && n_ended && !m_ne && !n_ne;
    status.hold_valid = hold_valid;
    status.out_free   = out_free;
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst || cmd.done) begin
      m_ended      <= 1'b0;
      n_ended      <= 1'b0;
      m_last_valid <= 1'b0;
      n_last_valid <= 1'b0;
    end else if (cmd.load) begin
      if (action == ACT_M_END) begin
        m_ended <= 1'b1;
      end
      if (action == ACT_N_END) begin
        n_ended <= 1'b1;
      end
      if (m_push) begin
        m_last_valid <= 1'b1;
      end
      if (n_push) begin
        n_last_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_push) begin
      m_last <= in_pos;
    end
    if (n_push) begin
      n_last <= in_pos;
    end
  end

  // hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.load && is_elem && (value != '0) && (order_drop || full_drop)) begin
      hold_valid <= 1'b1;
    end else if (push_res) begin
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold_kind <= order_drop ? KIND_ORDER : KIND_FULL;
      hold_row  <= row;
      hold_col  <= col;
      hold_diff <= '0;
    end else if (cmd.done) begin
      hold_kind <= KIND_DONE;
      hold_row  <= '0;
      hold_col  <= '0;
      hold_diff <= '0;
    end else if (cmd.step && step_emits) begin
      hold_kind <= KIND_DIFF;
      hold_row  <= (step_kind == STEP_N) ? n_head.row : m_head.row;
      hold_col  <= (step_kind == STEP_N) ? n_head.col : m_head.col;
      hold_diff <= step_diff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      kind       <= hold_kind;
      out_row    <= hold_row;
      out_col    <= hold_col;
      difference <= hold_diff;
      last       <= cmd.flush;
    end
  end

endmodule : ssm_dp

`default_nettype wire

// ===== design/ssm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssm_ctrl
// controller: input accept, merge steps, done marker and final handoff
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire ssm_pkg::status_t status,
  output      ssm_pkg::cmd_t    cmd
);
  import ssm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WAIT   = 2'd1;
  localparam logic [1:0] ST_SETTLE = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  logic [1:0] state, state_next;
  logic       room;

  always_comb begin
    room       = !status.hold_valid || status.out_free;
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WAIT;
        end
      end
      // queue head read settles after a write
      ST_WAIT: begin
        state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (status.step_kind != STEP_NONE) begin
          if (!status.step_emits || room) begin
            cmd.step = 1'b1;
          end
        end else if (status.done_cond) begin
          if (room) begin
            cmd.done   = 1'b1;
            state_next = ST_FLUSH;
          end
        end else if (!status.hold_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : ssm_ctrl

`default_nettype wire

// ===== design/sparse_matrix_subtract_merge.sv =====
// ----------------------------------------------------------------------------
// sparse_matrix_subtract_merge
// streaming sparse difference Q = M - N by a row-major merge of two queues
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_ready | action, row, col, value
//  out     | output    | out_valid/out_ready | kind, out_row, out_col,
//          |           |                     | difference, last
//
// one item at a time: accept, a wait for the queue head read, then one
// merge step per cycle while no emitting step stalls on the output; a
// cancelled pair takes a merge step too, and a done marker adds a handoff
// rst (synchronous, active high) empties both queues and clears end flags
// a held result waits in a hold register until the next result or the end
// of the item shows whether it is last; steps that emit stall on a full
// output register, steps that drop a zero difference never stall
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_subtract_merge #(
  parameter int MAX_DIM     = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input items
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         row,
  input  wire logic [7:0]         col,
  input  wire logic signed [31:0] value,
  // result items
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         kind,
  output      logic [7:0]         out_row,
  output      logic [7:0]         out_col,
  output      logic signed [32:0] difference,
  output      logic               last
);
  import ssm_pkg::*;

  cmd_t    cmd;     // load / step / done / flush
  status_t status;  // merge decision and output room

  // sequencer: accept, wait for head read, merge steps, final handoff
  ssm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .status, .cmd
  );

  // queues, stream state, subtractor, hold and output registers
  ssm_dp #(
    .MAX_DIM     (MAX_DIM),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk, .rst, .cmd, .status,
    .action, .row, .col, .value,
    .out_valid, .out_ready, .kind, .out_row, .out_col, .difference, .last
  );

`ifndef ASSERT_OFF
  // one item at a time: ready drops right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is still in work");

  // the done marker closes the results of its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DONE)) |-> last)
    else $error("done marker not flagged last");

  // zero differences are dropped, never emitted
  a_diff_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DIFF)) |-> (difference != '0))
    else $error("zero difference emitted");

  // no new result is produced while the held one cannot move on
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.step_emits && status.hold_valid) |-> status.out_free)
    else $error("held result overwritten");
`endif

endmodule : sparse_matrix_subtract_merge

`default_nettype wire
